>>> rtl/core/fgsa_pkg.sv
package fgsa_pkg;

    localparam int MAX_CELLS = 1024;
    localparam int VARS      = 4;
    localparam int ENTRIES   = MAX_CELLS * VARS;
    localparam int ENT_W     = $clog2(ENTRIES);
    localparam int CELL_W    = $clog2(MAX_CELLS);
    localparam int VAR_W     = (VARS > 1) ? $clog2(VARS) : 1;

    localparam int VAL_W   = 32;
    localparam int WGT_W   = 32;
    localparam int DIFF_W  = VAL_W + 1;
    localparam int PROD_W  = DIFF_W + WGT_W;
    localparam int ACC_W   = 48;
    localparam int SHIFT   = 20;
    localparam int GRAD_W  = 2 * ACC_W;

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    localparam logic [2:0] MODE_LOAD     = 3'd0;
    localparam logic [2:0] MODE_INNER    = 3'd1;
    localparam logic [2:0] MODE_BOUNDARY = 3'd2;
    localparam logic [2:0] MODE_READ     = 3'd3;
    localparam logic [2:0] MODE_CLEAR    = 3'd4;

    typedef enum logic [1:0] {
        OP_LOAD,
        OP_FACE,
        OP_READ,
        OP_CLEAR
    } op_t;

    typedef struct packed {
        op_t                      op;
        logic                     inner;
        logic                     zero;
        logic [CELL_W-1:0]        lcell;
        logic [CELL_W-1:0]        rcell;
        logic [VAR_W-1:0]         var_idx;
        logic signed [VAL_W-1:0]  value;
        logic signed [WGT_W-1:0]  wlx;
        logic signed [WGT_W-1:0]  wly;
        logic signed [WGT_W-1:0]  wrx;
        logic signed [WGT_W-1:0]  wry;
    } cmd_t;

    typedef struct packed {
        logic pop;
        logic init_done;
    } back_stat_t;

    function automatic logic [ENT_W-1:0] entry_idx(input logic [CELL_W-1:0] cidx,
                                                   input logic [VAR_W-1:0] vidx);
        entry_idx = ENT_W'(cidx) * ENT_W'(VARS) + ENT_W'(vidx);
    endfunction

    function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [ACC_W-1:0] acc,
                                                        input logic signed [PROD_W-1:0] prod,
                                                        input logic neg);
        logic signed [PROD_W:0]   t;
        logic signed [PROD_W:0]   sh;
        logic signed [PROD_W+1:0] sum;
        t   = neg ? -((PROD_W+1)'(prod)) : (PROD_W+1)'(prod);
        sh  = t >>> SHIFT;
        sum = (PROD_W+2)'(acc) + (PROD_W+2)'(sh);
        if (sum > (PROD_W+2)'(ACC_MAX))
            sat_acc = ACC_MAX;
        else if (sum < (PROD_W+2)'(ACC_MIN))
            sat_acc = ACC_MIN;
        else
            sat_acc = ACC_W'(sum);
    endfunction

endpackage

>>> rtl/core/face_gradient_scatter_accumulate.sv
// Face-loop gradient accumulator for 4 variables on up to 1024 cells.
// Input channel: in_valid/in_stall, one beat per item (mode plus fields).
// Items go into a two-deep queue; a sequencer behind it executes them on
// one value RAM and one gradient RAM, each with one write and one read port.
// Output channel: out_valid/out_stall, one beat per read item, in order.
// At the sequencer, a load writes the value RAM, a read fetches the gradient
// entry and registers the result, a clear zeroes all gradient entries, and a
// face steps through the variables, read-modify-writing the gradient RAM
// through its single read port one cell at a time (left, then right if inner).
// Unused modes and out-of-range loads or faces are dropped at the input.
// After reset, a clearing pass zeroes all 4096 gradient entries, one per
// cycle; in_stall stays high until it ends. The value RAM is not cleared.
// A stalled result holds on the output register; the sequencer then waits
// on the next read while loads and faces keep running.
module face_gradient_scatter_accumulate (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [2:0]          mode,
    input  logic [9:0]          left_cell,
    input  logic [9:0]          right_cell,
    input  logic [1:0]          var_index,
    input  logic signed [31:0]  value,
    input  logic signed [31:0]  weight_left_x,
    input  logic signed [31:0]  weight_left_y,
    input  logic signed [31:0]  weight_right_x,
    input  logic signed [31:0]  weight_right_y,
    output logic                out_valid,
    input  logic                out_stall,
    output logic signed [47:0]  grad_x,
    output logic signed [47:0]  grad_y
);

    fgsa_pkg::back_stat_t stat;
    fgsa_pkg::cmd_t       q_cmd;
    logic                 q_valid;

    fgsa_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .mode           (mode),
        .left_cell      (left_cell),
        .right_cell     (right_cell),
        .var_index      (var_index),
        .value          (value),
        .weight_left_x  (weight_left_x),
        .weight_left_y  (weight_left_y),
        .weight_right_x (weight_right_x),
        .weight_right_y (weight_right_y),
        .stat           (stat),
        .q_valid        (q_valid),
        .q_cmd          (q_cmd)
    );

    fgsa_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_cmd     (q_cmd),
        .stat      (stat),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .grad_x    (grad_x),
        .grad_y    (grad_y)
    );

endmodule

>>> rtl/core/fgsa_ram.sv
module fgsa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> rtl/core/fgsa_front.sv
module fgsa_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [2:0]                 mode,
    input  logic [9:0]                 left_cell,
    input  logic [9:0]                 right_cell,
    input  logic [1:0]                 var_index,
    input  logic signed [31:0]         value,
    input  logic signed [31:0]         weight_left_x,
    input  logic signed [31:0]         weight_left_y,
    input  logic signed [31:0]         weight_right_x,
    input  logic signed [31:0]         weight_right_y,
    input  fgsa_pkg::back_stat_t       stat,
    output logic                       q_valid,
    output fgsa_pkg::cmd_t             q_cmd
);

    fgsa_pkg::cmd_t q_reg [2];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     cnt_reg, cnt_next;

    fgsa_pkg::cmd_t cmd;
    logic           keep;
    logic           push;
    logic           lc_ok, rc_ok, var_ok;

    assign lc_ok  = 32'(left_cell) < 32'(fgsa_pkg::MAX_CELLS);
    assign rc_ok  = 32'(right_cell) < 32'(fgsa_pkg::MAX_CELLS);
    assign var_ok = 32'(var_index) < 32'(fgsa_pkg::VARS);

    always_comb
    begin
        cmd.op      = fgsa_pkg::OP_LOAD;
        cmd.inner   = (mode == fgsa_pkg::MODE_INNER);
        cmd.zero    = !(lc_ok && var_ok);
        cmd.lcell   = fgsa_pkg::CELL_W'(left_cell);
        cmd.rcell   = fgsa_pkg::CELL_W'(right_cell);
        cmd.var_idx = fgsa_pkg::VAR_W'(var_index);
        cmd.value   = value;
        cmd.wlx     = weight_left_x;
        cmd.wly     = weight_left_y;
        cmd.wrx     = weight_right_x;
        cmd.wry     = weight_right_y;
        keep        = 1'b0;
        unique case (mode)
            fgsa_pkg::MODE_LOAD:
            begin
                cmd.op = fgsa_pkg::OP_LOAD;
                keep   = lc_ok && var_ok;
            end
            fgsa_pkg::MODE_INNER, fgsa_pkg::MODE_BOUNDARY:
            begin
                cmd.op = fgsa_pkg::OP_FACE;
                keep   = lc_ok && rc_ok;
            end
            fgsa_pkg::MODE_READ:
            begin
                cmd.op = fgsa_pkg::OP_READ;
                keep   = 1'b1;
            end
            fgsa_pkg::MODE_CLEAR:
            begin
                cmd.op = fgsa_pkg::OP_CLEAR;
                keep   = 1'b1;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign in_stall = (cnt_reg == 2'd2) || !stat.init_done;
    assign push     = in_valid && !in_stall && keep;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_cmd    = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ stat.pop;
        cnt_next    = cnt_reg + 2'(push) - 2'(stat.pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

>>> rtl/core/fgsa_back.sv
module fgsa_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_valid,
    input  fgsa_pkg::cmd_t        q_cmd,
    output fgsa_pkg::back_stat_t  stat,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic signed [47:0]    grad_x,
    output logic signed [47:0]    grad_y
);

    typedef enum logic [12:0] {
        S_CLR  = 13'b0000000000001,
        S_IDLE = 13'b0000000000010,
        S_LD   = 13'b0000000000100,
        S_VL   = 13'b0000000001000,
        S_VR   = 13'b0000000010000,
        S_DIFF = 13'b0000000100000,
        S_MULL = 13'b0000001000000,
        S_ACCL = 13'b0000010000000,
        S_MULR = 13'b0000100000000,
        S_ACCR = 13'b0001000000000,
        S_RDG  = 13'b0010000000000,
        S_OUT  = 13'b0100000000000,
        S_SPARE = 13'b1000000000000
    } state_t;

    state_t                              state_reg, state_next;
    logic                                init_done_reg, init_done_next;
    logic [fgsa_pkg::ENT_W-1:0]          clr_cnt_reg, clr_cnt_next;
    logic [fgsa_pkg::VAR_W-1:0]          v_reg, v_next;
    logic                                out_valid_reg, out_valid_next;
    fgsa_pkg::cmd_t                      cmd_reg;
    logic signed [fgsa_pkg::VAL_W-1:0]   vl_reg;
    logic signed [fgsa_pkg::DIFF_W-1:0]  diff_reg;
    logic signed [fgsa_pkg::PROD_W-1:0]  px_reg, py_reg;
    logic [fgsa_pkg::GRAD_W-1:0]         grad_reg;
    logic signed [fgsa_pkg::ACC_W-1:0]   gx_reg, gy_reg;

    logic [fgsa_pkg::ENT_W-1:0]          li, ri;
    logic                                pop;
    logic                                val_we, val_re;
    logic [fgsa_pkg::ENT_W-1:0]          val_ra;
    logic [fgsa_pkg::VAL_W-1:0]          val_rd;
    logic                                grd_we, grd_re;
    logic [fgsa_pkg::ENT_W-1:0]          grd_wa, grd_ra;
    logic [fgsa_pkg::GRAD_W-1:0]         grd_wd, grd_rd;
    logic signed [fgsa_pkg::ACC_W-1:0]   acc_x, acc_y;
    logic                                last_var;
    logic                                out_free;

    assign li       = fgsa_pkg::entry_idx(cmd_reg.lcell, v_reg);
    assign ri       = fgsa_pkg::entry_idx(cmd_reg.rcell, v_reg);
    assign last_var = (v_reg == fgsa_pkg::VAR_W'(fgsa_pkg::VARS - 1));
    assign out_free = !out_valid_reg || !out_stall;
    assign acc_x    = fgsa_pkg::sat_acc(grad_reg[fgsa_pkg::ACC_W-1:0], px_reg,
                                        state_reg == S_ACCR);
    assign acc_y    = fgsa_pkg::sat_acc(grad_reg[fgsa_pkg::GRAD_W-1:fgsa_pkg::ACC_W], py_reg,
                                        state_reg == S_ACCR);

    fgsa_ram #(
        .WIDTH (fgsa_pkg::VAL_W),
        .DEPTH (fgsa_pkg::ENTRIES)
    ) u_val_ram (
        .clk     (clk),
        .wr_en   (val_we),
        .wr_addr (fgsa_pkg::entry_idx(cmd_reg.lcell, cmd_reg.var_idx)),
        .wr_data (cmd_reg.value),
        .rd_en   (val_re),
        .rd_addr (val_ra),
        .rd_data (val_rd)
    );

    fgsa_ram #(
        .WIDTH (fgsa_pkg::GRAD_W),
        .DEPTH (fgsa_pkg::ENTRIES)
    ) u_grad_ram (
        .clk     (clk),
        .wr_en   (grd_we),
        .wr_addr (grd_wa),
        .wr_data (grd_wd),
        .rd_en   (grd_re),
        .rd_addr (grd_ra),
        .rd_data (grd_rd)
    );

    always_comb
    begin
        state_next     = state_reg;
        init_done_next = init_done_reg;
        clr_cnt_next   = clr_cnt_reg;
        v_next         = v_reg;
        out_valid_next = out_valid_reg && out_stall;
        pop            = 1'b0;
        val_we         = 1'b0;
        val_re         = 1'b0;
        val_ra         = li;
        grd_we         = 1'b0;
        grd_wa         = li;
        grd_wd         = {acc_y, acc_x};
        grd_re         = 1'b0;
        grd_ra         = li;
        unique case (state_reg)
            S_CLR:
            begin
                grd_we       = 1'b1;
                grd_wa       = clr_cnt_reg;
                grd_wd       = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == fgsa_pkg::ENT_W'(fgsa_pkg::ENTRIES - 1))
                begin
                    init_done_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (q_valid)
                begin
                    pop    = 1'b1;
                    v_next = '0;
                    unique case (q_cmd.op)
                        fgsa_pkg::OP_LOAD:  state_next = S_LD;
                        fgsa_pkg::OP_FACE:  state_next = S_VL;
                        fgsa_pkg::OP_READ:  state_next = S_RDG;
                        fgsa_pkg::OP_CLEAR:
                        begin
                            clr_cnt_next = '0;
                            state_next   = S_CLR;
                        end
                        default:            state_next = S_IDLE;
                    endcase
                end
            end
            S_LD:
            begin
                val_we     = 1'b1;
                state_next = S_IDLE;
            end
            S_VL:
            begin
                val_re     = 1'b1;
                state_next = S_VR;
            end
            S_VR:
            begin
                val_re     = 1'b1;
                val_ra     = ri;
                state_next = S_DIFF;
            end
            S_DIFF:
            begin
                grd_re     = 1'b1;
                state_next = S_MULL;
            end
            S_MULL:
            begin
                state_next = S_ACCL;
            end
            S_ACCL:
            begin
                grd_we = 1'b1;
                if (cmd_reg.inner)
                begin
                    grd_re     = 1'b1;
                    grd_ra     = ri;
                    state_next = S_MULR;
                end
                else if (last_var)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    v_next     = v_reg + 1'b1;
                    state_next = S_VL;
                end
            end
            S_MULR:
            begin
                state_next = S_ACCR;
            end
            S_ACCR:
            begin
                grd_we = 1'b1;
                grd_wa = ri;
                if (last_var)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    v_next     = v_reg + 1'b1;
                    state_next = S_VL;
                end
            end
            S_RDG:
            begin
                grd_re     = 1'b1;
                grd_ra     = fgsa_pkg::entry_idx(cmd_reg.lcell, cmd_reg.var_idx);
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign stat      = '{pop: pop, init_done: init_done_reg};
    assign out_valid = out_valid_reg;
    assign grad_x    = gx_reg;
    assign grad_y    = gy_reg;

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && q_valid)
        begin
            cmd_reg <= q_cmd;
        end
        if (state_reg == S_VR)
        begin
            vl_reg <= val_rd;
        end
        if (state_reg == S_DIFF)
        begin
            diff_reg <= fgsa_pkg::DIFF_W'(signed'(val_rd)) - fgsa_pkg::DIFF_W'(vl_reg);
        end
        if (state_reg == S_MULL)
        begin
            grad_reg <= grd_rd;
            px_reg   <= diff_reg * cmd_reg.wlx;
            py_reg   <= diff_reg * cmd_reg.wly;
        end
        if (state_reg == S_MULR)
        begin
            grad_reg <= grd_rd;
            px_reg   <= diff_reg * cmd_reg.wrx;
            py_reg   <= diff_reg * cmd_reg.wry;
        end
        if (state_reg == S_OUT && out_free)
        begin
            gx_reg <= cmd_reg.zero ? '0 : grd_rd[fgsa_pkg::ACC_W-1:0];
            gy_reg <= cmd_reg.zero ? '0 : grd_rd[fgsa_pkg::GRAD_W-1:fgsa_pkg::ACC_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            init_done_reg <= 1'b0;
            clr_cnt_reg   <= '0;
            v_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            init_done_reg <= init_done_next;
            clr_cnt_reg   <= clr_cnt_next;
            v_reg         <= v_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

>>> tb/sv/fgsa_checker.sv
module fgsa_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic [2:0]         mode,
    input  logic [9:0]         left_cell,
    input  logic [9:0]         right_cell,
    input  logic [1:0]         var_index,
    input  logic signed [31:0] value,
    input  logic signed [31:0] weight_left_x,
    input  logic signed [31:0] weight_left_y,
    input  logic signed [31:0] weight_right_x,
    input  logic signed [31:0] weight_right_y,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic signed [47:0] grad_x,
    input  logic signed [47:0] grad_y,
    output int                 errors,
    output int                 pending
);

    typedef struct packed {
        logic signed [47:0] gx;
        logic signed [47:0] gy;
    } grad_pair_t;

    logic signed [31:0] cell_vals [fgsa_pkg::ENTRIES];
    logic signed [47:0] grad_xs [fgsa_pkg::ENTRIES];
    logic signed [47:0] grad_ys [fgsa_pkg::ENTRIES];
    grad_pair_t         grad_expect_q[$];

    // floor(+/- d*w / 2^20) then saturating add into the accumulator
    function automatic logic signed [47:0] accum(input logic signed [47:0] acc,
                                                 input logic signed [32:0] d,
                                                 input logic signed [31:0] w,
                                                 input logic neg);
        logic signed [66:0] p;
        logic signed [66:0] s;
        p = 67'(d) * 67'(w);
        if (neg)
            p = -p;
        p = p >>> 20;
        s = 67'(acc) + p;
        if (s > 67'(fgsa_pkg::ACC_MAX))
            return fgsa_pkg::ACC_MAX;
        if (s < 67'(fgsa_pkg::ACC_MIN))
            return fgsa_pkg::ACC_MIN;
        return s[47:0];
    endfunction

    task automatic apply_beat();
        int li;
        int ri;
        logic signed [32:0] d;
        grad_pair_t g;
        case (mode)
            fgsa_pkg::MODE_LOAD:
                cell_vals[left_cell * fgsa_pkg::VARS + var_index] = value;
            fgsa_pkg::MODE_INNER, fgsa_pkg::MODE_BOUNDARY:
                for (int v = 0; v < fgsa_pkg::VARS; v++)
                begin
                    li = left_cell * fgsa_pkg::VARS + v;
                    ri = right_cell * fgsa_pkg::VARS + v;
                    d = 33'(cell_vals[ri]) - 33'(cell_vals[li]);
                    grad_xs[li] = accum(grad_xs[li], d, weight_left_x, 1'b0);
                    grad_ys[li] = accum(grad_ys[li], d, weight_left_y, 1'b0);
                    if (mode == fgsa_pkg::MODE_INNER)
                    begin
                        grad_xs[ri] = accum(grad_xs[ri], d, weight_right_x, 1'b1);
                        grad_ys[ri] = accum(grad_ys[ri], d, weight_right_y, 1'b1);
                    end
                end
            fgsa_pkg::MODE_READ:
            begin
                g.gx = grad_xs[left_cell * fgsa_pkg::VARS + var_index];
                g.gy = grad_ys[left_cell * fgsa_pkg::VARS + var_index];
                grad_expect_q.push_back(g);
            end
            fgsa_pkg::MODE_CLEAR:
                for (int i = 0; i < fgsa_pkg::ENTRIES; i++)
                begin
                    grad_xs[i] = '0;
                    grad_ys[i] = '0;
                end
            default: ;
        endcase
    endtask

    initial
    begin
        errors = 0;
        pending = 0;
        for (int i = 0; i < fgsa_pkg::ENTRIES; i++)
        begin
            cell_vals[i] = '0;
            grad_xs[i] = '0;
            grad_ys[i] = '0;
        end
    end

    always @(posedge clk)
    begin
        grad_pair_t g;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (grad_expect_q.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected beat gx=%0d gy=%0d", grad_x, grad_y);
                end
                else
                begin
                    g = grad_expect_q.pop_front();
                    if (g.gx !== grad_x || g.gy !== grad_y)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch exp gx=%0d gy=%0d got gx=%0d gy=%0d",
                                     g.gx, g.gy, grad_x, grad_y);
                    end
                end
            end
            if (in_valid && !in_stall)
                apply_beat();
            pending = grad_expect_q.size();
        end
    end

endmodule

>>> tb/sv/testbench.sv
module testbench;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [2:0]         mode;
    logic [9:0]         left_cell;
    logic [9:0]         right_cell;
    logic [1:0]         var_index;
    logic signed [31:0] value;
    logic signed [31:0] weight_left_x;
    logic signed [31:0] weight_left_y;
    logic signed [31:0] weight_right_x;
    logic signed [31:0] weight_right_y;
    logic               out_valid;
    logic               out_stall;
    logic signed [47:0] grad_x;
    logic signed [47:0] grad_y;
    int                 errors;
    int                 pending;
    bit                 loaded [fgsa_pkg::ENTRIES];
    bit                 calm;
    bit                 hold_off;

    face_gradient_scatter_accumulate i_dut (.*);

    fgsa_checker i_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #60_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // receiver stalls: random bursts, one long hold-off, none at the end
    initial
    begin
        int n;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off)
            begin
                out_stall <= 1'b1;
                repeat (600) @(posedge clk);
                out_stall <= 1'b0;
                wait (!hold_off);
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                n = $urandom_range(1, 19);
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    task automatic send(input logic [2:0] m, input logic [9:0] lc, input logic [9:0] rc,
                        input logic [1:0] vi, input logic [31:0] val,
                        input logic [31:0] wlx, input logic [31:0] wly,
                        input logic [31:0] wrx, input logic [31:0] wry);
        int n;
        if (!calm && $urandom_range(0, 7) == 0)
        begin
            n = $urandom_range(1, 19);
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
        in_valid       <= 1'b1;
        mode           <= m;
        left_cell      <= lc;
        right_cell     <= rc;
        var_index      <= vi;
        value          <= val;
        weight_left_x  <= wlx;
        weight_left_y  <= wly;
        weight_right_x <= wrx;
        weight_right_y <= wry;
        if (m == fgsa_pkg::MODE_LOAD)
            loaded[lc * fgsa_pkg::VARS + vi] = 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    function automatic bit cell_ready(input logic [9:0] c);
        for (int v = 0; v < fgsa_pkg::VARS; v++)
            if (!loaded[c * fgsa_pkg::VARS + v])
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic logic [31:0] rnd_word();
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'($signed($urandom_range(0, 2000)) - 1000);
            default: return $urandom();
        endcase
    endfunction

    // mostly a small pool of loaded cells so faces keep hitting the same gradients
    task automatic random_item(input bit small_pool);
        logic [9:0] lc;
        logic [9:0] rc;
        logic [2:0] m;
        int r;
        lc = small_pool ? 10'($urandom_range(0, 15)) : 10'($urandom());
        rc = small_pool ? 10'($urandom_range(0, 15)) : 10'($urandom());
        r = $urandom_range(0, 99);
        if (r < 25)
            m = fgsa_pkg::MODE_LOAD;
        else if (r < 50)
            m = fgsa_pkg::MODE_INNER;
        else if (r < 65)
            m = fgsa_pkg::MODE_BOUNDARY;
        else if (r < 94)
            m = fgsa_pkg::MODE_READ;
        else if (r < 95)
            m = fgsa_pkg::MODE_CLEAR;
        else
            m = 3'($urandom_range(5, 7));
        if ((m == fgsa_pkg::MODE_INNER || m == fgsa_pkg::MODE_BOUNDARY)
            && !(cell_ready(lc) && cell_ready(rc)))
            m = fgsa_pkg::MODE_READ;
        send(m, lc, rc, 2'($urandom()), rnd_word(), rnd_word(), rnd_word(),
             rnd_word(), rnd_word());
    endtask

    initial
    begin
        in_valid = 1'b0;
        mode = '0;
        left_cell = '0;
        right_cell = '0;
        var_index = '0;
        value = '0;
        weight_left_x = '0;
        weight_left_y = '0;
        weight_right_x = '0;
        weight_right_y = '0;
        calm = 1'b0;
        hold_off = 1'b0;
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, saturation, same cell, unused modes
        for (int v = 0; v < fgsa_pkg::VARS; v++)
        begin
            send(fgsa_pkg::MODE_LOAD, 10'd0, '0, 2'(v), 32'h8000_0000, '0, '0, '0, '0);
            send(fgsa_pkg::MODE_LOAD, 10'd1023, '0, 2'(v), 32'h7FFF_FFFF, '0, '0, '0, '0);
        end
        send(fgsa_pkg::MODE_INNER, 10'd0, 10'd1023, '0, '0, 32'h8000_0000, 32'h7FFF_FFFF,
             32'h7FFF_FFFF, 32'h8000_0000);
        send(fgsa_pkg::MODE_INNER, 10'd0, 10'd1023, '0, '0, 32'h8000_0000, 32'h7FFF_FFFF,
             32'h7FFF_FFFF, 32'h8000_0000);
        send(fgsa_pkg::MODE_BOUNDARY, 10'd1023, 10'd0, '0, '0, 32'h0000_0001, 32'hFFFF_FFFF,
             '1, '1);
        send(fgsa_pkg::MODE_INNER, 10'd1023, 10'd1023, '0, '0, '1, '1, '1, '1);
        send(fgsa_pkg::MODE_READ, 10'd0, '0, 2'd0, '0, '0, '0, '0, '0);
        send(fgsa_pkg::MODE_READ, 10'd1023, '0, 2'd3, '1, '1, '1, '1, '1);
        send(3'd5, '1, '1, '1, '1, '1, '1, '1, '1);
        send(3'd7, '0, '0, '0, '0, '0, '0, '0, '0);
        send(fgsa_pkg::MODE_CLEAR, '0, '0, '0, '0, '0, '0, '0, '0);
        send(fgsa_pkg::MODE_READ, 10'd0, '0, 2'd0, '0, '0, '0, '0, '0);

        for (int i = 0; i < 1900; i++)
        begin
            if (i == 600)
            begin
                hold_off = 1'b1;
                for (int k = 0; k < 20; k++)
                    send(fgsa_pkg::MODE_READ, 10'($urandom()), '0, 2'($urandom()),
                         '0, '0, '0, '0, '0);
                hold_off = 1'b0;
            end
            if (i == 1000)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
                wait (pending == 0);
                @(posedge clk);
            end
            if (i == 1750)
                calm = 1'b1;
            random_item($urandom_range(0, 9) != 0);
        end
        in_valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        repeat (50) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

>>> face_gradient_scatter_accumulate.f
rtl/core/fgsa_pkg.sv
rtl/core/fgsa_ram.sv
rtl/core/fgsa_front.sv
rtl/core/fgsa_back.sv
rtl/core/face_gradient_scatter_accumulate.sv
tb/sv/fgsa_checker.sv
tb/sv/testbench.sv
